// ===== src/swcms_pkg.sv =====
// Shared types and constants of the sliding window count-min sketch.
// No dependencies; imported by every module of the block.
package swcms_pkg;

    localparam int MAX_ROWS   = 8;
    localparam int IDX_W      = 15;
    localparam int CNT_W      = 16;
    localparam int CFG_W      = 21;
    localparam int TIME_W     = 31;
    localparam int GRP_BITS   = 6;
    localparam int MOD_STEPS  = 6;
    localparam int DIVD_W     = 34;
    localparam int CFG_IDX_W  = 8;
    localparam int S_DATA_W   = 168;

    localparam logic [CNT_W-1:0]     CNT_CAP          = 16'h8000;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLUSH_PERIOD = 8'd1;
    localparam logic [CFG_W-1:0]     WINDOW_RESET     = 21'd1024;
    localparam logic [CFG_W-1:0]     PERIOD_RESET     = 21'd2048;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_QUERY  = 1'b1
    } kind_t;

    typedef struct packed {
        logic load_item;
        logic row_first;
        logic row_next;
        logic mod_load;
        logic mod_step;
        logic off_quo;
        logic off_rem;
        logic off_frac;
        logic off_sum;
        logic div_t_start;
        logic add_t;
        logic stamp_rd;
        logic stamp_wr;
        logic gclr_first;
        logic gclr_wr;
        logic ctr_rd;
        logic ctr_wr;
        logic min_upd;
        logic sweep_wr;
        logic out_load;
    } swcms_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic mod_last;
        logic row_last;
        logic clr_last;
        logic sweep_last;
        logic stamp_diff;
        logic age_ok;
        logic is_query;
        logic out_free;
    } swcms_sts_t;

endpackage

// ===== src/swcms_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on swcms_pkg.
module swcms_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [swcms_pkg::DIVD_W-1:0] dividend,
    input  logic [swcms_pkg::CFG_W-1:0]  divisor,
    output logic                        busy,
    output logic [swcms_pkg::DIVD_W-1:0] quotient,
    output logic [swcms_pkg::CFG_W-1:0]  remainder
);
    import swcms_pkg::*;

    localparam int CNT_BITS = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0]   quo_reg;
    logic [CFG_W-1:0]    rem_reg;
    logic [CFG_W-1:0]    dsr_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic [CFG_W:0]      trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(DIVD_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= fits ? CFG_W'(trial - {1'b0, dsr_reg}) : trial[CFG_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/swcms_ctrl.sv =====
// Sequencer of the sketch: walks each accepted item through the rows.
// Depends on swcms_pkg; drives swcms_dp through the command struct.
module swcms_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  swcms_pkg::swcms_sts_t sts,
    output swcms_pkg::swcms_cmd_t cmd
);
    import swcms_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_MOD, ST_OFFQ, ST_OFFR, ST_OFFF, ST_OFFS, ST_ADD,
        ST_DIVT, ST_DIVT_WAIT, ST_DECIDE, ST_STAMP_RD, ST_STAMP_CHK, ST_GCLR,
        ST_CTR_RD, ST_CTR_UPD
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;
    logic   row_done;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        row_done   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.load_item = 1'b1;
                    cmd.row_first = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.mod_load = 1'b1;
                state_next   = ST_MOD;
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last) state_next = ST_OFFQ;
            end
            ST_OFFQ: begin
                cmd.off_quo = 1'b1;
                state_next  = ST_OFFR;
            end
            ST_OFFR: begin
                cmd.off_rem = 1'b1;
                state_next  = ST_OFFF;
            end
            ST_OFFF: begin
                cmd.off_frac = 1'b1;
                state_next   = ST_OFFS;
            end
            ST_OFFS: begin
                cmd.off_sum = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD: begin
                cmd.add_t  = 1'b1;
                state_next = ST_DIVT;
            end
            ST_DIVT: begin
                cmd.div_t_start = 1'b1;
                state_next      = ST_DIVT_WAIT;
            end
            ST_DIVT_WAIT: if (!sts.div_busy) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (!sts.is_query) state_next = ST_STAMP_RD;
                else if (sts.age_ok) state_next = ST_CTR_RD;
                else row_done = 1'b1;
            end
            ST_STAMP_RD: begin
                cmd.stamp_rd = 1'b1;
                state_next   = ST_STAMP_CHK;
            end
            ST_STAMP_CHK: begin
                if (sts.stamp_diff) begin
                    cmd.stamp_wr   = 1'b1;
                    cmd.gclr_first = 1'b1;
                    state_next     = ST_GCLR;
                end else begin
                    state_next = ST_CTR_RD;
                end
            end
            ST_GCLR: begin
                cmd.gclr_wr = 1'b1;
                if (sts.clr_last) state_next = ST_CTR_RD;
            end
            ST_CTR_RD: begin
                cmd.ctr_rd = 1'b1;
                state_next = ST_CTR_UPD;
            end
            ST_CTR_UPD: begin
                if (sts.is_query) cmd.min_upd = 1'b1;
                else cmd.ctr_wr = 1'b1;
                row_done = 1'b1;
            end
            default: state_next = ST_CLEAR;
        endcase

        // end of a row: next row, or hand the result over
        if (row_done) begin
            if (!sts.row_last) begin
                cmd.row_next = 1'b1;
                state_next   = ST_LOAD;
            end else if (!sts.is_query) begin
                state_next = ST_IDLE;
            end else if (sts.out_free) begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end else begin
                state_next = state_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

// ===== src/swcms_dp.sv =====
// Datapath of the sketch: item and config registers, index reduction,
// offset and age arithmetic, counter and stamp memories, output register.
// Depends on swcms_pkg and swcms_div.
module swcms_dp #(
    parameter int ROWS  = 8,
    parameter int WIDTH = 32768
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  swcms_pkg::swcms_cmd_t             cmd,
    output swcms_pkg::swcms_sts_t             sts,
    input  logic [swcms_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_wr,
    input  logic [swcms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swcms_pkg::CFG_W-1:0]       cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swcms_pkg::CNT_W-1:0]       m_tdata
);
    import swcms_pkg::*;

    localparam int RB     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IW     = $clog2(WIDTH);
    localparam int GB     = IW - GRP_BITS;
    localparam int SW     = RB + IW;
    localparam int TW     = SW - GRP_BITS;
    localparam int GROUPS = WIDTH / (1 << GRP_BITS);
    localparam int DIV_D  = GROUPS * ROWS;
    localparam int NW     = 13;

    // offset = period * gnum / DIV_D, split as Q * gnum + (R * gnum) / DIV_D with
    // Q, R the quotient and remainder of period by DIV_D; both divisions by DIV_D
    // are reciprocal multiplications, exact over the operand ranges
    localparam int              OFF_L  = $clog2(DIV_D);
    localparam int              FRAC_W = 2 * OFF_L;
    localparam int              MQ_W   = CFG_W + 2;
    localparam int              MF_W   = FRAC_W + 2;
    localparam longint unsigned M_QUO  = (64'd1 << (CFG_W + OFF_L)) / DIV_D + 1;
    localparam longint unsigned M_FRAC = (64'd1 << (FRAC_W + OFF_L)) / DIV_D + 1;

    // item
    kind_t                  kind_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [CNT_W-1:0]       inc_reg;
    logic [IDX_W-1:0]       rix_reg [MAX_ROWS];

    logic [CFG_W-1:0]       window_reg;
    logic [CFG_W-1:0]       period_reg;
    logic [CFG_W-1:0]       period_eff;

    logic [RB-1:0]          row_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [2:0]             modk_reg;
    logic [CFG_W-1:0]       mod_cmp;
    logic [CFG_W-1:0]       offq_reg;
    logic [OFF_L-1:0]       offr_reg;
    logic [CFG_W-1:0]       offqg_reg;
    logic [FRAC_W-1:0]      offrg_reg;
    logic [CFG_W-1:0]       h_reg;
    logic [TIME_W:0]        t_reg;
    logic [GRP_BITS-1:0]    gk_reg;
    logic [SW-1:0]          sweep_reg;
    logic [CNT_W-1:0]       best_reg;
    logic [CNT_W-1:0]       best_next;
    logic                   m_tvalid_reg;
    logic [CNT_W-1:0]       m_tdata_reg;

    logic [IW-1:0]          idx;
    logic [GB-1:0]          grp;
    logic [NW-1:0]          gnum;

    logic [CFG_W+MQ_W-1:0]    quo_prod;
    logic [CFG_W+NW-1:0]      qd_prod;
    logic [CFG_W+NW-1:0]      qg_prod;
    logic [FRAC_W-1:0]        rg_prod;
    logic [FRAC_W+MF_W-1:0]   frac_prod;

    logic [CNT_W-1:0]       ctr_mem [2**SW];
    logic                   stamp_mem [2**TW];
    logic [CNT_W-1:0]       ctr_q;
    logic                   stamp_q;

    logic                   ctr_we;
    logic [SW-1:0]          ctr_wa;
    logic [CNT_W-1:0]       ctr_wd;
    logic                   stamp_we;
    logic [TW-1:0]          stamp_wa;
    logic                   stamp_wd;

    logic                   div_start;
    logic [DIVD_W-1:0]      div_dividend;
    logic [CFG_W-1:0]       div_divisor;
    logic                   div_busy;
    logic [DIVD_W-1:0]      div_quo;
    logic [CFG_W-1:0]       div_rem;

    assign period_eff = (period_reg == '0) ? CFG_W'(1) : period_reg;
    assign idx        = idx_reg[IW-1:0];
    assign grp        = idx[IW-1:GRP_BITS];
    assign gnum       = NW'(row_reg) * NW'(GROUPS) + NW'(grp);
    assign mod_cmp    = CFG_W'(WIDTH) << modk_reg;

    assign quo_prod  = (CFG_W+MQ_W)'(period_eff) * (CFG_W+MQ_W)'(M_QUO);
    assign qd_prod   = (CFG_W+NW)'(offq_reg) * (CFG_W+NW)'(DIV_D);
    assign qg_prod   = (CFG_W+NW)'(offq_reg) * (CFG_W+NW)'(gnum);
    assign rg_prod   = FRAC_W'(offr_reg) * FRAC_W'(gnum);
    assign frac_prod = (FRAC_W+MF_W)'(offrg_reg) * (FRAC_W+MF_W)'(M_FRAC);

    // a query's last row may lower the minimum in the cycle the result is loaded
    assign best_next = (cmd.min_upd && ctr_q < best_reg) ? ctr_q : best_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_wr) begin
            if (cfg_index == REG_WINDOW_SIZE) window_reg <= cfg_data;
            if (cfg_index == REG_FLUSH_PERIOD) period_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= kind_t'(s_tuser);
            now_reg  <= s_tdata[TIME_W-1:0];
            inc_reg  <= s_tdata[TIME_W +: CNT_W];
            for (int i = 0; i < MAX_ROWS; i++)
                rix_reg[i] <= s_tdata[TIME_W + CNT_W + i*IDX_W +: IDX_W];
            best_reg <= CNT_CAP;
        end else begin
            best_reg <= best_next;
        end

        if (cmd.row_first) row_reg <= '0;
        else if (cmd.row_next) row_reg <= row_reg + 1'b1;

        // index modulo WIDTH by shifted compare and subtract
        if (cmd.mod_load) begin
            idx_reg  <= rix_reg[3'(row_reg)];
            modk_reg <= 3'(MOD_STEPS - 1);
        end else if (cmd.mod_step) begin
            if ({{(CFG_W-IDX_W){1'b0}}, idx_reg} >= mod_cmp)
                idx_reg <= idx_reg - IDX_W'(mod_cmp);
            modk_reg <= modk_reg - 1'b1;
        end

        if (cmd.off_quo) offq_reg <= CFG_W'(quo_prod >> (CFG_W + OFF_L));
        if (cmd.off_rem) begin
            offr_reg  <= OFF_L'(period_eff - qd_prod[CFG_W-1:0]);
            offqg_reg <= qg_prod[CFG_W-1:0];
        end
        if (cmd.off_frac) offrg_reg <= rg_prod;
        if (cmd.off_sum) h_reg <= offqg_reg + CFG_W'(frac_prod >> (FRAC_W + OFF_L));

        if (cmd.add_t) t_reg <= (TIME_W+1)'(now_reg) + (TIME_W+1)'(h_reg);

        if (cmd.gclr_first) gk_reg <= '0;
        else if (cmd.gclr_wr) gk_reg <= gk_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sweep_reg <= '0;
        else if (cmd.sweep_wr) sweep_reg <= sweep_reg + 1'b1;
    end

    always_comb begin
        ctr_we   = 1'b0;
        ctr_wa   = {row_reg, idx};
        ctr_wd   = ctr_q + inc_reg;
        stamp_we = 1'b0;
        stamp_wa = {row_reg, grp};
        stamp_wd = div_quo[0];
        if (cmd.sweep_wr) begin
            ctr_we   = 1'b1;
            ctr_wa   = sweep_reg;
            ctr_wd   = '0;
            stamp_we = 1'b1;
            stamp_wa = sweep_reg[SW-1:GRP_BITS];
            stamp_wd = 1'b0;
        end else if (cmd.gclr_wr) begin
            // partial last group: skip slots past the row end
            ctr_we = ({1'b0, grp, gk_reg} < (IW+1)'(WIDTH));
            ctr_wa = {row_reg, grp, gk_reg};
            ctr_wd = '0;
        end else if (cmd.ctr_wr) begin
            ctr_we = 1'b1;
        end
        if (cmd.stamp_wr) stamp_we = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
        if (cmd.ctr_rd) ctr_q <= ctr_mem[{row_reg, idx}];
    end

    always_ff @(posedge aclk) begin
        if (stamp_we) stamp_mem[stamp_wa] <= stamp_wd;
        if (cmd.stamp_rd) stamp_q <= stamp_mem[{row_reg, grp}];
    end

    assign div_start    = cmd.div_t_start;
    assign div_dividend = DIVD_W'(t_reg);
    assign div_divisor  = period_eff;

    swcms_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_tdata_reg <= (best_next == CNT_CAP) ? '0 : best_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        sts            = '0;
        sts.div_busy   = div_busy;
        sts.mod_last   = (modk_reg == '0);
        sts.row_last   = (row_reg == RB'(ROWS - 1));
        sts.clr_last   = (gk_reg == '1);
        sts.sweep_last = (sweep_reg == '1);
        sts.stamp_diff = (stamp_q != div_quo[0]);
        sts.age_ok     = (div_rem > window_reg);
        sts.is_query   = (kind_reg == KIND_QUERY);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

// ===== src/sliding_window_count_min_sketch_unit.sv =====
// Sliding window count-min sketch, top level.
// Input items on s_*, one estimate per query item on m_*, registers written on cfg_*.
// Each row of an item: index reduction, the group time offset by reciprocal
// multiplication, the age division by the flush period on a bit-serial divider,
// a decision step and the counter access; an insert row reads the stamp of its
// group before the counter access and clears the group when the stamp differs.
// Items are taken one at a time: s_tready is high only between items.
// An estimate waits in an output register; the next item may be accepted meanwhile,
// and a later query only stalls at its end while that register is still full.
// Inserts produce no output item.
// After reset the counter and stamp memories are cleared by a pass of
// 2**(clog2(ROWS) + clog2(WIDTH)) addresses (ROWS=1 counts as two rows): 262144 at
// the defaults; no item is accepted then, register writes are.
// Registers: index 0 window size, index 1 flush period; write only while idle.
// Depends on swcms_pkg, swcms_ctrl, swcms_dp, swcms_div.
module sliding_window_count_min_sketch_unit #(
    parameter int ROWS  = 8,
    parameter int WIDTH = 32768
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // time_now[30:0], increment[46:31], row_index_0..7[15 bits each from 47], pad
    input  logic [swcms_pkg::S_DATA_W-1:0]     s_tdata,
    // kind
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // estimate[15:0]
    output logic [swcms_pkg::CNT_W-1:0]        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swcms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swcms_pkg::CFG_W-1:0]        cfg_data
);
    import swcms_pkg::*;

    swcms_cmd_t cmd;
    swcms_sts_t sts;

    assign cfg_ready = 1'b1;

    swcms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swcms_dp #(
        .ROWS  (ROWS),
        .WIDTH (WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // one item in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item in flight");

    // divider never busy while waiting for an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && sts.div_busy))
        else $error("divider busy while idle");

    // capped minimum is reported as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && m_tdata == CNT_CAP))
        else $error("estimate holds the cap value");

endmodule
